// ===== hdl/adc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_pkg
// Types and codes shared by the automatic door controller modules.
// ----------------------------------------------------------------------------
package adc_pkg;

  localparam logic [2:0] ST_FROZEN  = 3'd0;
  localparam logic [2:0] ST_CLOSED  = 3'd1;
  localparam logic [2:0] ST_OPENING = 3'd2;
  localparam logic [2:0] ST_OPEN    = 3'd3;
  localparam logic [2:0] ST_WAITING = 3'd4;
  localparam logic [2:0] ST_CLOSING = 3'd5;

  localparam logic [1:0] MODE_REPAIR = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_FAULT  = 2'd3;

  localparam logic [2:0] DRIVE_OFF   = 3'd0;
  localparam logic [2:0] DRIVE_OPEN  = 3'd1;
  localparam logic [2:0] DRIVE_CLOSE = 3'd6;

  localparam logic [7:0] WAIT_TICKS_RESET = 8'd5;

  typedef struct packed {
    logic [2:0] door_state;
    logic [2:0] drive;
    logic [1:0] mode;
    logic [7:0] hold_count;
    logic       halt;
  } adc_state_t;

  typedef struct packed {
    logic [2:0] drive_word;
    logic [2:0] door_state;
    logic [1:0] mode;
    logic       halted;
  } adc_result_t;

endpackage

// ===== hdl/automatic_door_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// automatic_door_controller
// Door state machine with mode switches, buttons, sensors and a wait timer.
// ----------------------------------------------------------------------------
// One sample is taken per clock while in_stall is low; its result is written
// to the result register, or to the skid register if the output is stalled.
// The state update is a single pass of next-state logic into the state
// registers. The two-entry output buffer takes one more sample while the
// output is stalled; throughput is one sample per clock with no output stall.
// wait_ticks may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module automatic_door_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] input_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  drive_word,
  output logic [2:0]  door_state,
  output logic [1:0]  mode,
  output logic        halted
);

  logic [7:0]           wait_ticks;
  adc_pkg::adc_state_t  state;
  adc_pkg::adc_state_t  state_next;
  adc_pkg::adc_result_t result_next;
  adc_pkg::adc_result_t out_data;
  adc_pkg::adc_result_t skid_data;
  logic                 skid_valid;
  logic                 accept;
  logic                 out_free;

  adc_next u_next (
    .cur        (state),
    .input_bits (input_bits),
    .wait_ticks (wait_ticks),
    .nxt        (state_next)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  assign result_next.drive_word = state_next.drive;
  assign result_next.door_state = state_next.door_state;
  assign result_next.mode       = state_next.mode;
  assign result_next.halted     = state_next.halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= adc_pkg::WAIT_TICKS_RESET;
    end else if (cfg_we) begin
      wait_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.door_state <= adc_pkg::ST_CLOSED;
      state.drive      <= adc_pkg::DRIVE_CLOSE;
      state.mode       <= adc_pkg::MODE_REPAIR;
      state.hold_count <= '0;
      state.halt       <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result_next;
      end
    end else if (accept) begin
      skid_data <= result_next;
    end
  end

  assign drive_word = out_data.drive_word;
  assign door_state = out_data.door_state;
  assign mode       = out_data.mode;
  assign halted     = out_data.halted;

endmodule

// ===== hdl/adc_next.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_next
// Next-state logic of the door controller for one input sample.
// ----------------------------------------------------------------------------
module adc_next (
  input  adc_pkg::adc_state_t cur,
  input  logic [11:0]         input_bits,
  input  logic [7:0]          wait_ticks,
  output adc_pkg::adc_state_t nxt
);

  logic s1, s2;
  logic e1, e2, e3, e4;
  logic x0, x1, x2, x3, x4, x5;
  logic reopen;

  assign s1 = input_bits[0];
  assign s2 = input_bits[1];
  assign e1 = input_bits[2];
  assign e2 = input_bits[3];
  assign e3 = input_bits[4];
  assign e4 = input_bits[5];
  assign x0 = input_bits[6];
  assign x1 = input_bits[7];
  assign x2 = input_bits[8];
  assign x3 = input_bits[9];
  assign x4 = input_bits[10];
  assign x5 = input_bits[11];

  always_comb begin
    nxt    = cur;
    reopen = 1'b0;
    if (!cur.halt) begin
      priority if (s1 && !s2) begin
        nxt.mode       = adc_pkg::MODE_REPAIR;
        nxt.door_state = adc_pkg::ST_FROZEN;
        nxt.drive      = adc_pkg::DRIVE_OFF;
      end else if (s1 && s2) begin
        nxt.mode       = adc_pkg::MODE_FAULT;
        nxt.door_state = adc_pkg::ST_FROZEN;
        nxt.drive      = adc_pkg::DRIVE_OFF;
        nxt.halt       = 1'b1;
      end else begin
        // automatic for s2 set, manual otherwise
        nxt.mode = s2 ? adc_pkg::MODE_AUTO : adc_pkg::MODE_MANUAL;
        reopen   = s2 ? (!x2 || !x3 || !x5) : (!x5 || !e1 || !e3);
        unique case (cur.door_state)
          adc_pkg::ST_FROZEN: begin
            if (x0 && x1 && x4) begin
              nxt.door_state = adc_pkg::ST_OPENING;
            end else if (!x0 && x1 && !x4) begin
              nxt.door_state = adc_pkg::ST_CLOSED;
            end else if (x0 && !x1 && x4) begin
              nxt.door_state = adc_pkg::ST_OPEN;
            end
          end
          adc_pkg::ST_CLOSED: begin
            if (s2 ? (!x2 || !x3) : (!e1 || !e3)) begin
              nxt.door_state = adc_pkg::ST_OPENING;
            end
          end
          adc_pkg::ST_OPENING: begin
            if (!x1 && x0) begin
              nxt.door_state = adc_pkg::ST_OPEN;
            end else begin
              nxt.drive = adc_pkg::DRIVE_OPEN;
            end
          end
          adc_pkg::ST_OPEN: begin
            if (s2) begin
              nxt.door_state = adc_pkg::ST_WAITING;
              nxt.hold_count = '0;
            end else if (!e2 || !e4) begin
              nxt.door_state = adc_pkg::ST_CLOSING;
            end
          end
          adc_pkg::ST_WAITING: begin
            if (!s2) begin
              nxt.door_state = adc_pkg::ST_OPEN;
            end else if (cur.hold_count >= wait_ticks) begin
              nxt.door_state = adc_pkg::ST_CLOSING;
            end else begin
              nxt.hold_count = cur.hold_count + 8'd1;
            end
          end
          adc_pkg::ST_CLOSING: begin
            if (reopen) begin
              nxt.drive      = adc_pkg::DRIVE_OPEN;
              nxt.door_state = adc_pkg::ST_OPENING;
            end else if (!x0 && x1 && !x4) begin
              nxt.door_state = adc_pkg::ST_CLOSED;
            end else begin
              nxt.drive = adc_pkg::DRIVE_CLOSE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
